// File: src/pbe_pkg.sv
// shared types and constants of the parenthesized boolean expression evaluator
`default_nettype none

package pbe_pkg;

	// width of one stacked value
	localparam int unsigned VALUE_W = 31;
	localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

	// result status codes
	typedef enum logic [2:0] {
		ST_FALSE     = 3'd0,
		ST_TRUE      = 3'd1,
		ST_MALFORMED = 3'd2,
		ST_UNMATCHED = 3'd3,
		ST_MISSING   = 3'd4,
		ST_OVERFLOW  = 3'd5
	} status_t;

	// no latched error shares the code of a false result
	localparam status_t ERR_NONE = ST_FALSE;

	// operator codes held on the operator stack
	typedef enum logic [2:0] {
		OP_NOT = 3'd0,
		OP_AND = 3'd1,
		OP_OR  = 3'd2,
		OP_EQ  = 3'd3,
		OP_GT  = 3'd4,
		OP_LT  = 3'd5
	} op_t;

	// stack commands: every non-hold command loads the top cell with the new data
	typedef enum logic [1:0] {
		STK_HOLD = 2'd0,
		STK_PUSH = 2'd1,
		STK_LOAD = 2'd2,
		STK_POP  = 2'd3
	} stk_op_t;

	// per-cell command along the chain
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_UP   = 2'd1,
		CELL_DOWN = 2'd2
	} cell_cmd_t;

	// character codes
	localparam logic [7:0] CH_NOT   = 8'h21;
	localparam logic [7:0] CH_AND   = 8'h26;
	localparam logic [7:0] CH_OR    = 8'h7C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

`default_nettype wire

// File: src/pbe_char_if.sv
// character input channel
`default_nettype none

interface pbe_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       char_valid;
	logic       line_end;

	modport source (output valid, ch, char_valid, line_end, input ready);
	modport sink   (input valid, ch, char_valid, line_end, output ready);
endinterface

`default_nettype wire

// File: src/pbe_result_if.sv
// result output channel
`default_nettype none

interface pbe_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [30:0] final_value;

	modport source (output valid, status, final_value, input ready);
	modport sink   (input valid, status, final_value, output ready);
endinterface

`default_nettype wire

// File: src/pbe_cell.sv
// one stack cell: holds an entry and takes it from the neighbor above or below
`default_nettype none

module pbe_cell #(
	parameter int unsigned WIDTH = 31
) (
	input  wire logic                    clk,
	input  wire pbe_pkg::cell_cmd_t      cmd,
	input  wire logic [WIDTH-1:0]        up_val,
	input  wire logic [WIDTH-1:0]        down_val,
	output logic      [WIDTH-1:0]        val
);

	logic [WIDTH-1:0] val_q;

	// entry register, payload only
	always_ff @(posedge clk) begin
		unique case (cmd)
			pbe_pkg::CELL_UP:   val_q <= up_val;
			pbe_pkg::CELL_DOWN: val_q <= down_val;
			default:            val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

`default_nettype wire

// File: src/pbe_stack.sv
// stack built as a chain of cells, top at cell 0
`default_nettype none

module pbe_stack #(
	parameter int unsigned WIDTH = 31,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic             clk,
	input  wire pbe_pkg::stk_op_t op,
	input  wire logic [WIDTH-1:0] din,
	output logic      [WIDTH-1:0] top,
	output logic      [WIDTH-1:0] second
);

	logic [WIDTH-1:0]   cell_val [DEPTH];
	pbe_pkg::cell_cmd_t cell_cmd [DEPTH];

	// top cell takes new data on every command
	always_comb begin
		cell_cmd[0] = (op == pbe_pkg::STK_HOLD) ? pbe_pkg::CELL_HOLD : pbe_pkg::CELL_UP;
	end

	pbe_cell #(.WIDTH(WIDTH)) u_cell0 (
		.clk      (clk),
		.cmd      (cell_cmd[0]),
		.up_val   (din),
		.down_val ((DEPTH > 1) ? cell_val[(DEPTH > 1) ? 1 : 0] : din),
		.val      (cell_val[0])
	);

	// lower cells shift down on push and up on pop
	for (genvar i = 1; i < DEPTH; i++) begin : g_cell
		logic [WIDTH-1:0] below;

		always_comb begin
			unique case (op)
				pbe_pkg::STK_PUSH: cell_cmd[i] = pbe_pkg::CELL_UP;
				pbe_pkg::STK_POP:  cell_cmd[i] = pbe_pkg::CELL_DOWN;
				default:           cell_cmd[i] = pbe_pkg::CELL_HOLD;
			endcase
		end

		if (i == DEPTH - 1) begin : g_last
			assign below = '0;
		end else begin : g_mid
			assign below = cell_val[i+1];
		end

		pbe_cell #(.WIDTH(WIDTH)) u_cell (
			.clk      (clk),
			.cmd      (cell_cmd[i]),
			.up_val   (cell_val[i-1]),
			.down_val (below),
			.val      (cell_val[i])
		);
	end

	assign top = cell_val[0];

	if (DEPTH > 1) begin : g_second
		assign second = cell_val[1];
	end else begin : g_no_second
		assign second = '0;
	end

endmodule

`default_nettype wire

// File: src/paren_bool_expr_evaluator_core.sv
// top level: fully parenthesized boolean expression evaluator
//
//  channel  | role   | payload                          | handshake
//  ---------+--------+----------------------------------+-------------
//  chars    | sink   | ch[7:0], char_valid, line_end    | valid/ready
//  results  | source | status[2:0], final_value[30:0]   | valid/ready
//
// one character is taken per cycle; the operator stack top and the two upper value
// cells are read and rewritten in that same cycle, so the chain of cells sets the rate
// a line end gives its result through an output register, or through a skid stage while
// the output register holds an untaken result; chars stalls only while both hold untaken results
// reset clears counters, flags, the accumulator and the latched error; stack cells are never cleared
`default_nettype none

module paren_bool_expr_evaluator_core #(
	parameter int unsigned VALUE_DEPTH    = 16,
	parameter int unsigned OPERATOR_DEPTH = 16,
	parameter int unsigned PAREN_LIMIT    = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	pbe_char_if.sink       chars,
	pbe_result_if.source   results
);

	localparam int unsigned VW  = pbe_pkg::VALUE_W;
	localparam int unsigned VCW = $clog2(VALUE_DEPTH + 1);
	localparam int unsigned OCW = $clog2(OPERATOR_DEPTH + 1);
	localparam int unsigned PW  = $clog2(PAREN_LIMIT + 1);

	// control state
	logic [VCW-1:0]       vcnt_q, vcnt_n;
	logic [OCW-1:0]       ocnt_q, ocnt_n;
	logic [PW-1:0]        pdepth_q, pdepth_n;
	logic [VW-1:0]        acc_q, acc_n;
	logic                 innum_q, innum_n;
	logic                 prevop_q, prevop_n;
	pbe_pkg::status_t     err_q, err_n;

	// stack ports
	pbe_pkg::stk_op_t     v_op, o_op;
	logic [VW-1:0]        v_din, v_top, v_second;
	logic [2:0]           o_din, o_top, o_second;

	// output register and skid stage
	logic                 out_valid_q, skid_valid_q;
	logic [2:0]           out_status_q, skid_status_q;
	logic [VW-1:0]        out_value_q, skid_value_q;

	logic                 fire, take, produce;
	logic                 is_digit, is_op;
	pbe_pkg::op_t         op_code;
	logic [VW+3:0]        acc_prod;
	logic [VW-1:0]        acc_sat;
	logic [VW-1:0]        top1, second1;
	logic [VCW-1:0]       vcnt1;
	logic [VW-1:0]        bin_res;
	pbe_pkg::status_t     res_status;
	logic [VW-1:0]        res_value;

	assign fire    = chars.valid && chars.ready;
	assign take    = fire && chars.char_valid && (err_q == pbe_pkg::ERR_NONE);
	assign produce = fire && chars.line_end;

	// character classes
	assign is_digit = (chars.ch >= pbe_pkg::CH_ZERO) && (chars.ch <= pbe_pkg::CH_NINE);

	always_comb begin
		is_op   = 1'b1;
		op_code = pbe_pkg::OP_NOT;
		unique case (chars.ch)
			pbe_pkg::CH_NOT: op_code = pbe_pkg::OP_NOT;
			pbe_pkg::CH_AND: op_code = pbe_pkg::OP_AND;
			pbe_pkg::CH_OR:  op_code = pbe_pkg::OP_OR;
			pbe_pkg::CH_EQ:  op_code = pbe_pkg::OP_EQ;
			pbe_pkg::CH_GT:  op_code = pbe_pkg::OP_GT;
			pbe_pkg::CH_LT:  op_code = pbe_pkg::OP_LT;
			default:         is_op   = 1'b0;
		endcase
	end

	// decimal accumulate with saturation: acc * 8 + acc * 2 + digit
	assign acc_prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
		+ {{VW{1'b0}}, chars.ch[3:0]};
	assign acc_sat  = (acc_prod > {4'b0, pbe_pkg::VALUE_MAX}) ? pbe_pkg::VALUE_MAX
		: acc_prod[VW-1:0];

	// operands as seen after a pending number is pushed
	assign top1    = innum_q ? acc_q : v_top;
	assign second1 = innum_q ? v_top : v_second;
	assign vcnt1   = innum_q ? vcnt_q + VCW'(1) : vcnt_q;

	// binary operator on b (lower) and a (top)
	always_comb begin
		unique case (pbe_pkg::op_t'(o_top))
			pbe_pkg::OP_AND: bin_res = VW'((top1 != '0) && (second1 != '0));
			pbe_pkg::OP_OR:  bin_res = VW'((top1 != '0) || (second1 != '0));
			pbe_pkg::OP_EQ:  bin_res = VW'(second1 == top1);
			pbe_pkg::OP_GT:  bin_res = VW'(second1 > top1);
			default:         bin_res = VW'(second1 < top1);
		endcase
	end

	// per-character next state and stack commands
	always_comb begin
		vcnt_n   = vcnt_q;
		ocnt_n   = ocnt_q;
		pdepth_n = pdepth_q;
		acc_n    = acc_q;
		innum_n  = innum_q;
		prevop_n = prevop_q;
		err_n    = err_q;
		v_op     = pbe_pkg::STK_HOLD;
		v_din    = acc_q;
		o_op     = pbe_pkg::STK_HOLD;
		o_din    = o_second;

		if (take) begin
			if (is_digit) begin
				acc_n    = acc_sat;
				innum_n  = 1'b1;
				prevop_n = 1'b0;
			end else begin
				innum_n = 1'b0;
				acc_n   = '0;
				if (innum_q && (vcnt_q >= VCW'(VALUE_DEPTH))) begin
					err_n = pbe_pkg::ST_OVERFLOW;
				end else begin
					// digit run ends here
					if (innum_q) begin
						v_op   = pbe_pkg::STK_PUSH;
						v_din  = acc_q;
						vcnt_n = vcnt1;
					end
					if (is_op) begin
						prevop_n = 1'b1;
						if (prevop_q && (ocnt_q != '0)) begin
							o_op  = pbe_pkg::STK_LOAD;
							o_din = op_code;
						end else if (ocnt_q >= OCW'(OPERATOR_DEPTH)) begin
							err_n = pbe_pkg::ST_OVERFLOW;
						end else begin
							o_op   = pbe_pkg::STK_PUSH;
							o_din  = op_code;
							ocnt_n = ocnt_q + OCW'(1);
						end
					end else begin
						prevop_n = 1'b0;
						if (chars.ch == pbe_pkg::CH_OPEN) begin
							if (pdepth_q >= PW'(PAREN_LIMIT)) begin
								err_n = pbe_pkg::ST_OVERFLOW;
							end else begin
								pdepth_n = pdepth_q + PW'(1);
							end
						end else if (chars.ch == pbe_pkg::CH_CLOSE) begin
							if (pdepth_q == '0) begin
								err_n = pbe_pkg::ST_UNMATCHED;
							end else begin
								pdepth_n = pdepth_q - PW'(1);
								if (ocnt_q == '0) begin
									if (vcnt1 == '0) begin
										err_n = pbe_pkg::ST_MISSING;
									end
								end else begin
									ocnt_n = ocnt_q - OCW'(1);
									o_op   = pbe_pkg::STK_POP;
									o_din  = o_second;
									if (pbe_pkg::op_t'(o_top) == pbe_pkg::OP_NOT) begin
										if (vcnt1 == '0) begin
											err_n = pbe_pkg::ST_MISSING;
										end else begin
											v_din = VW'(top1 == '0);
											v_op  = innum_q ? pbe_pkg::STK_PUSH
												: pbe_pkg::STK_LOAD;
										end
									end else if (vcnt1 < VCW'(2)) begin
										err_n = pbe_pkg::ST_MISSING;
									end else begin
										v_din = bin_res;
										if (innum_q) begin
											v_op   = pbe_pkg::STK_LOAD;
											vcnt_n = vcnt_q;
										end else begin
											v_op   = pbe_pkg::STK_POP;
											vcnt_n = vcnt_q - VCW'(1);
										end
									end
								end
							end
						end
					end
				end
			end
		end
	end

	// line end: close a pending digit run and judge the stacks
	always_comb begin
		logic [VCW-1:0] end_cnt;
		logic [VW-1:0]  end_top;
		pbe_pkg::status_t end_err;

		end_cnt = vcnt_n;
		end_top = (v_op != pbe_pkg::STK_HOLD) ? v_din : v_top;
		end_err = err_n;
		if ((err_n == pbe_pkg::ERR_NONE) && innum_n) begin
			if (vcnt_n >= VCW'(VALUE_DEPTH)) begin
				end_err = pbe_pkg::ST_OVERFLOW;
			end else begin
				end_cnt = vcnt_n + VCW'(1);
				end_top = acc_n;
			end
		end

		res_value = '0;
		if (end_err != pbe_pkg::ERR_NONE) begin
			res_status = end_err;
		end else if ((end_cnt != VCW'(1)) || (ocnt_n != '0) || (pdepth_n != '0)) begin
			res_status = pbe_pkg::ST_MALFORMED;
		end else begin
			res_value  = end_top;
			res_status = (end_top != '0) ? pbe_pkg::ST_TRUE : pbe_pkg::ST_FALSE;
		end
	end

	// control registers, cleared at every line end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q   <= '0;
			ocnt_q   <= '0;
			pdepth_q <= '0;
			acc_q    <= '0;
			innum_q  <= 1'b0;
			prevop_q <= 1'b0;
			err_q    <= pbe_pkg::ERR_NONE;
		end else if (produce) begin
			vcnt_q   <= '0;
			ocnt_q   <= '0;
			pdepth_q <= '0;
			acc_q    <= '0;
			innum_q  <= 1'b0;
			prevop_q <= 1'b0;
			err_q    <= pbe_pkg::ERR_NONE;
		end else begin
			vcnt_q   <= vcnt_n;
			ocnt_q   <= ocnt_n;
			pdepth_q <= pdepth_n;
			acc_q    <= acc_n;
			innum_q  <= innum_n;
			prevop_q <= prevop_n;
			err_q    <= err_n;
		end
	end

	// value and operator stacks
	pbe_stack #(.WIDTH(VW), .DEPTH(VALUE_DEPTH)) u_value_stack (
		.clk    (clk),
		.op     (v_op),
		.din    (v_din),
		.top    (v_top),
		.second (v_second)
	);

	pbe_stack #(.WIDTH(3), .DEPTH(OPERATOR_DEPTH)) u_operator_stack (
		.clk    (clk),
		.op     (o_op),
		.din    (o_din),
		.top    (o_top),
		.second (o_second)
	);

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || results.ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= produce;
			end
		end else if (produce) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || results.ready) begin
			if (skid_valid_q) begin
				out_status_q <= skid_status_q;
				out_value_q  <= skid_value_q;
			end else if (produce) begin
				out_status_q <= res_status;
				out_value_q  <= res_value;
			end
		end else if (produce) begin
			skid_status_q <= res_status;
			skid_value_q  <= res_value;
		end
	end

	assign chars.ready         = !skid_valid_q;
	assign results.valid       = out_valid_q;
	assign results.status      = out_status_q;
	assign results.final_value = out_value_q;

endmodule

`default_nettype wire

// File: tb/pbe_line_checker.sv
`timescale 1ns / 1ps
// checker: predicts each line's verdict from the character stream and compares the results
module pbe_line_checker #(
	parameter int unsigned VALUE_DEPTH    = 16,
	parameter int unsigned OPERATOR_DEPTH = 16,
	parameter int unsigned PAREN_LIMIT    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	pbe_char_if         chars,
	pbe_result_if       results,
	output int unsigned fault_count,
	output int unsigned line_backlog
);

	typedef struct packed {
		pbe_pkg::status_t            status;
		logic [pbe_pkg::VALUE_W-1:0] value;
	} verdict_t;

	// verdicts of finished lines still waiting for their result transaction
	verdict_t verdicts_due[$];

	// shadow of the evaluator state
	logic [pbe_pkg::VALUE_W-1:0] operands [VALUE_DEPTH];
	int unsigned                 n_operands;
	pbe_pkg::op_t                operators [OPERATOR_DEPTH];
	int unsigned                 n_operators;
	int unsigned                 n_open;
	logic [pbe_pkg::VALUE_W-1:0] digits;
	logic                        in_digits;
	logic                        after_operator;
	pbe_pkg::status_t            fault;

	function automatic void clear_expr();
		n_operands     = 0;
		n_operators    = 0;
		n_open         = 0;
		digits         = '0;
		in_digits      = 1'b0;
		after_operator = 1'b0;
		fault          = pbe_pkg::ERR_NONE;
	endfunction

	// first error of the line wins
	function automatic void latch_fault(pbe_pkg::status_t code);
		if (fault == pbe_pkg::ERR_NONE)
			fault = code;
	endfunction

	function automatic void push_operand(logic [pbe_pkg::VALUE_W-1:0] v);
		if (n_operands >= VALUE_DEPTH) begin
			latch_fault(pbe_pkg::ST_OVERFLOW);
		end else begin
			operands[n_operands] = v;
			n_operands++;
		end
	endfunction

	// a digit run ends: its value goes on the operand stack
	function automatic void flush_digits();
		if (in_digits) begin
			in_digits = 1'b0;
			push_operand(digits);
			digits = '0;
		end
	endfunction

	// one character of a line with no error latched
	function automatic void parse_char(logic [7:0] c);
		logic [63:0]                 wide;
		logic                        is_op;
		pbe_pkg::op_t                op;
		pbe_pkg::op_t                top;
		logic [pbe_pkg::VALUE_W-1:0] a;
		logic [pbe_pkg::VALUE_W-1:0] b;
		logic                        r;
		// digits accumulate with saturation
		if (c >= pbe_pkg::CH_ZERO && c <= pbe_pkg::CH_NINE) begin
			wide = 64'(digits) * 64'd10 + 64'(c - pbe_pkg::CH_ZERO);
			digits = (wide > 64'(pbe_pkg::VALUE_MAX)) ? pbe_pkg::VALUE_MAX
				: wide[pbe_pkg::VALUE_W-1:0];
			in_digits = 1'b1;
			after_operator = 1'b0;
			return;
		end
		flush_digits();
		if (fault != pbe_pkg::ERR_NONE)
			return;
		is_op = 1'b1;
		op = pbe_pkg::OP_NOT;
		case (c)
			pbe_pkg::CH_NOT: op = pbe_pkg::OP_NOT;
			pbe_pkg::CH_AND: op = pbe_pkg::OP_AND;
			pbe_pkg::CH_OR:  op = pbe_pkg::OP_OR;
			pbe_pkg::CH_EQ:  op = pbe_pkg::OP_EQ;
			pbe_pkg::CH_GT:  op = pbe_pkg::OP_GT;
			pbe_pkg::CH_LT:  op = pbe_pkg::OP_LT;
			default: is_op = 1'b0;
		endcase
		// in a run of operator characters the last one replaces the top
		if (is_op) begin
			if (after_operator && n_operators > 0)
				operators[n_operators-1] = op;
			else if (n_operators >= OPERATOR_DEPTH)
				latch_fault(pbe_pkg::ST_OVERFLOW);
			else begin
				operators[n_operators] = op;
				n_operators++;
			end
			after_operator = 1'b1;
			return;
		end
		after_operator = 1'b0;
		if (c == pbe_pkg::CH_OPEN) begin
			if (n_open >= PAREN_LIMIT)
				latch_fault(pbe_pkg::ST_OVERFLOW);
			else
				n_open++;
		end else if (c == pbe_pkg::CH_CLOSE) begin
			// close: pop one operator, if there is one, and apply it
			if (n_open == 0) begin
				latch_fault(pbe_pkg::ST_UNMATCHED);
				return;
			end
			n_open--;
			if (n_operators == 0) begin
				if (n_operands == 0)
					latch_fault(pbe_pkg::ST_MISSING);
				return;
			end
			n_operators--;
			top = operators[n_operators];
			if (top == pbe_pkg::OP_NOT) begin
				if (n_operands == 0)
					latch_fault(pbe_pkg::ST_MISSING);
				else
					operands[n_operands-1] =
						pbe_pkg::VALUE_W'(operands[n_operands-1] == '0);
				return;
			end
			if (n_operands < 2) begin
				latch_fault(pbe_pkg::ST_MISSING);
				return;
			end
			a = operands[n_operands-1];
			b = operands[n_operands-2];
			n_operands -= 2;
			case (top)
				pbe_pkg::OP_AND: r = (a != '0) && (b != '0);
				pbe_pkg::OP_OR:  r = (a != '0) || (b != '0);
				pbe_pkg::OP_EQ:  r = (a == b);
				pbe_pkg::OP_GT:  r = (b > a);
				default:         r = (b < a);
			endcase
			push_operand(pbe_pkg::VALUE_W'(r));
		end
	endfunction

	// follow both channels, predict on character transactions, compare result transactions
	always @(posedge clk or negedge arst_n) begin
		verdict_t    want;
		int unsigned bad;
		if (!arst_n) begin
			clear_expr();
			verdicts_due.delete();
			fault_count  <= 0;
			line_backlog <= 0;
		end else begin
			bad = 0;
			if (chars.valid && chars.ready) begin
				if (chars.char_valid && fault == pbe_pkg::ERR_NONE)
					parse_char(chars.ch);
				if (chars.line_end) begin
					if (fault == pbe_pkg::ERR_NONE)
						flush_digits();
					want.value = '0;
					if (fault != pbe_pkg::ERR_NONE) begin
						want.status = fault;
					end else if (n_operands != 1 || n_operators != 0 || n_open != 0) begin
						want.status = pbe_pkg::ST_MALFORMED;
					end else begin
						want.value  = operands[0];
						want.status = (operands[0] != '0) ? pbe_pkg::ST_TRUE
							: pbe_pkg::ST_FALSE;
					end
					verdicts_due.push_back(want);
					clear_expr();
				end
			end
			if (results.valid && results.ready) begin
				if (verdicts_due.size() == 0) begin
					$display("%0t unexpected result: expected none, actual status %0d value %0d",
						$time, results.status, results.final_value);
					bad++;
				end else begin
					want = verdicts_due.pop_front();
					if (results.status !== want.status) begin
						$display("%0t status mismatch: expected %0d, actual %0d",
							$time, want.status, results.status);
						bad++;
					end
					if (results.final_value !== want.value) begin
						$display("%0t final_value mismatch: expected %0d, actual %0d",
							$time, want.value, results.final_value);
						bad++;
					end
				end
			end
			fault_count  <= fault_count + bad;
			line_backlog <= verdicts_due.size();
		end
	end

endmodule

// File: tb/tb_paren_bool_expr_evaluator_core.sv
`timescale 1ns / 1ps
// testbench top: feeds expression lines to the evaluator and gives the verdict
module tb_paren_bool_expr_evaluator_core;

	localparam int unsigned VALUE_DEPTH    = 16;
	localparam int unsigned OPERATOR_DEPTH = 16;
	localparam int unsigned PAREN_LIMIT    = 16;
	localparam int unsigned RANDOM_CHARS   = 1200;

	logic clk = 1'b0;
	logic arst_n;

	pbe_char_if   chars ();
	pbe_result_if results ();

	int unsigned fault_count;
	int unsigned line_backlog;
	int unsigned chars_sent = 0;
	int unsigned bare_steps = 0;
	int unsigned lines_sent = 0;
	bit          chars_idle = 1'b0;
	bit          results_idle = 1'b0;

	paren_bool_expr_evaluator_core #(
		.VALUE_DEPTH   (VALUE_DEPTH),
		.OPERATOR_DEPTH(OPERATOR_DEPTH),
		.PAREN_LIMIT   (PAREN_LIMIT)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.results(results)
	);

	pbe_line_checker #(
		.VALUE_DEPTH   (VALUE_DEPTH),
		.OPERATOR_DEPTH(OPERATOR_DEPTH),
		.PAREN_LIMIT   (PAREN_LIMIT)
	) u_line_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.chars       (chars),
		.results     (results),
		.fault_count (fault_count),
		.line_backlog(line_backlog)
	);

	always #4 clk = ~clk;

	// run limit
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// result side: random stall before each result transaction while results_idle is set
	initial begin
		int unsigned stall;
		results.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = results_idle ? $urandom_range(0, 8) : 0;
			if (stall != 0) begin
				results.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			results.ready <= 1'b1;
			do @(posedge clk); while (!results.valid);
		end
	end

	// one character transaction, after a random gap while chars_idle is set
	task automatic send_char(input logic [7:0] c, input logic cv, input logic le);
		int unsigned gap;
		gap = chars_idle ? $urandom_range(0, 8) : 0;
		if (gap != 0) begin
			chars.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars.valid      <= 1'b1;
		chars.ch         <= c;
		chars.char_valid <= cv;
		chars.line_end   <= le;
		do @(posedge clk); while (!chars.ready);
		if (cv || le)
			chars_sent++;
		else
			bare_steps++;
	endtask

	// a whole line, with the odd bare step mixed in
	task automatic send_line(input string text, input bit bare_end);
		for (int i = 0; i < text.len(); i++) begin
			if ($urandom_range(0, 31) == 0)
				send_char(8'($urandom), 1'b0, 1'b0);
			send_char(text[i], 1'b1, !bare_end && i == text.len() - 1);
		end
		if (bare_end || text.len() == 0)
			send_char(8'($urandom), 1'b0, 1'b1);
		lines_sent++;
	endtask

	// hold off until every predicted verdict has come back
	task automatic drain();
		chars.valid <= 1'b0;
		@(posedge clk);
		while (line_backlog != 0)
			@(posedge clk);
	endtask

	function automatic string num_text();
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick < 3)
			return "0";
		if (pick < 13)
			return $sformatf("%0d", $urandom_range(1, 20));
		if (pick < 15)
			return $sformatf("%0d", $urandom);
		// long runs saturate
		if (pick < 17)
			return $sformatf("%0d%0d", $urandom, $urandom);
		if (pick == 17)
			return "2147483647";
		return $sformatf("00%0d", $urandom_range(0, 9));
	endfunction

	function automatic string op_text();
		string s;
		case ($urandom_range(0, 13))
			0:  s = "&&";
			1:  s = "||";
			2:  s = "==";
			3:  s = "!=";
			4:  s = ">";
			5:  s = "<";
			6:  s = "&";
			7:  s = "|";
			8:  s = "=";
			9:  s = "<>";
			10: s = "><";
			11: s = "&|";
			12: s = "!";
			default: s = ">=";
		endcase
		return s;
	endfunction

	function automatic string pad();
		if ($urandom_range(0, 3) == 0)
			return " ";
		return "";
	endfunction

	// expression nested by wrapping; well-formed unless a lone ! is picked as a binary operator
	function automatic string good_expr(int unsigned levels);
		string e;
		e = num_text();
		repeat (levels) begin
			case ($urandom_range(0, 5))
				0: e = $sformatf("(%s%s%s%s%s)", e, pad(), op_text(), pad(), num_text());
				1: e = $sformatf("(%s%s%s)", num_text(), op_text(), e);
				2: e = $sformatf("(!%s%s)", pad(), e);
				3: e = $sformatf("(%s)", e);
				default: e = $sformatf("(%s%s(%s%s%s))", e, op_text(), num_text(),
					op_text(), num_text());
			endcase
		end
		return e;
	endfunction

	// damaged expression: a junk character inserted, one dropped, or a stray paren
	function automatic string break_expr(string e);
		string       junk;
		int unsigned pos;
		int unsigned k;
		junk = "()!&|=<> 07x";
		pos = $urandom_range(1, e.len());
		k = $urandom_range(0, junk.len() - 1);
		case ($urandom_range(0, 3))
			0: e = $sformatf("%s%s%s", e.substr(0, pos - 1), junk.substr(k, k),
				e.substr(pos, e.len() - 1));
			1: e = $sformatf("%s%s", e.substr(0, pos - 2), e.substr(pos, e.len() - 1));
			2: e = $sformatf("%s)", e);
			default: e = $sformatf("(%s", e);
		endcase
		return e;
	endfunction

	// lines that run a stack or the paren count right up to and past its limit
	function automatic string overflow_expr();
		string e;
		case ($urandom_range(0, 2))
			0: begin
				e = num_text();
				repeat ($urandom_range(PAREN_LIMIT - 1, PAREN_LIMIT + 1))
					e = $sformatf("(%s)", e);
			end
			1: begin
				e = num_text();
				repeat ($urandom_range(VALUE_DEPTH - 2, VALUE_DEPTH))
					e = $sformatf("%s %s", e, num_text());
			end
			default: begin
				e = "1";
				repeat ($urandom_range(OPERATOR_DEPTH - 1, OPERATOR_DEPTH + 1))
					e = $sformatf("%s %s", e, op_text());
			end
		endcase
		return e;
	endfunction

	// stimulus and verdict
	initial begin
		int unsigned directed_sent;
		int unsigned pick;
		int unsigned n;
		string       text;
		arst_n           = 1'b0;
		chars.valid      = 1'b0;
		chars.ch         = '0;
		chars.char_valid = 1'b0;
		chars.line_end   = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines
		send_line("(1&(2>1))", 1'b0);    // and, greater than
		send_line("(0!=(1<0))", 1'b0);   // operator run acts as equal, less than
		send_line("(!7)", 1'b0);         // not
		send_line(")", 1'b0);            // close without open
		send_line("()", 1'b0);           // close with nothing on either stack
		send_line("", 1'b1);             // bare line end on an empty line, malformed
		directed_sent = chars_sent;
		drain();

		// random lines
		while (chars_sent < directed_sent + RANDOM_CHARS) begin
			if (lines_sent % 8 == 0) begin
				pick = $urandom_range(0, 3);
				chars_idle   = pick[0];
				results_idle = pick[1];
			end
			pick = $urandom_range(0, 99);
			if (pick < 88) begin
				if (pick < 62)
					text = good_expr($urandom_range(0, 4));
				else if (pick < 76)
					text = break_expr(good_expr($urandom_range(1, 4)));
				else
					text = overflow_expr();
				send_line(text, $urandom_range(0, 4) == 0);
			end else begin
				// noise over the full byte range
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++)
					send_char(8'($urandom_range(0, 255)), 1'b1, i == n - 1);
				lines_sent++;
			end
			if ($urandom_range(0, 19) == 0)
				drain();
		end

		drain();
		repeat (16) @(posedge clk);
		$display("covered %0d characters in %0d lines with %0d bare steps,",
			chars_sent, lines_sent, bare_steps);
		$display("random gaps and stalls on both channels, %0d mismatches", fault_count);
		if (fault_count == 0 && line_backlog == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
src/pbe_pkg.sv
src/pbe_char_if.sv
src/pbe_result_if.sv
src/pbe_cell.sv
src/pbe_stack.sv
src/paren_bool_expr_evaluator_core.sv
tb/pbe_line_checker.sv
tb/tb_paren_bool_expr_evaluator_core.sv
